[src/circular_deque_macros.svh]
// Assertion macros shared by the deque checker
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Check cons in the same cycle as ante
`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Check cons in the cycle after ante
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

[src/cdq_pkg.sv]
// Types and constants of the circular deque
`default_nettype none

package cdq_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      action_type                 action;
      logic signed [VALUE_W-1:0]  value;
   } req_word_type;

   typedef struct packed {
      status_type                 status;
      logic                       is_empty;
      logic                       is_full;
      logic signed [VALUE_W-1:0]  front_value;
      logic signed [VALUE_W-1:0]  rear_value;
      logic                       ends_valid;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_LOAD = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic exec;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

[src/cdq_ctrl.sv]
// Controller state machine of the circular deque
`default_nettype none

module cdq_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    rsp_ready,
   input  cdq_pkg::dp_status_type dp_status,
   output cdq_pkg::ctrl_cmd_type  cmd
);
   import cdq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!dp_status.rsp_busy || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/cdq_datapath.sv]
// Datapath of the circular deque: ring memory, indices, count and result register
`default_nettype none

module cdq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  cdq_pkg::req_word_type                req_word,
   input  wire                                  csr_wr_en,
   input  wire [cdq_pkg::CAP_W-1:0]             csr_wr_data,
   input  cdq_pkg::ctrl_cmd_type                cmd,
   output cdq_pkg::dp_status_type               dp_status,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output cdq_pkg::rsp_word_type                rsp_word
);
   import cdq_pkg::*;

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int WIDE_W = (CW > CAP_W) ? CW : CAP_W;

   logic [VALUE_W-1:0] mem [DEPTH];

   logic [CAP_W-1:0]   cap_ff,   cap_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [IDX_W-1:0]   rear_ff,  rear_in;
   logic [CW-1:0]      count_ff, count_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic [VALUE_W-1:0] front_rd_ff;
   logic [VALUE_W-1:0] rear_rd_ff;

   logic [CW-1:0]      eff_cap;
   logic               is_push;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic               empty_now;
   logic               full_now;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CW-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt >= cap) ? '0 : IDX_W'(nxt);
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx,
                                                 input logic [CW-1:0] cap);
      if (idx == '0 || CW'(idx) >= cap) begin
         return IDX_W'(cap - CW'(1));
      end
      return idx - IDX_W'(1);
   endfunction

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (WIDE_W'(cap_ff) > WIDE_W'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   assign is_push   = (req_word.action == ACT_PUSH_FRONT) ||
                      (req_word.action == ACT_PUSH_REAR);
   assign empty_now = (count_ff == '0);
   assign full_now  = (count_ff >= eff_cap);

   always_comb begin
      cap_in    = cap_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         front_in = '0;
         rear_in  = '0;
         count_in = '0;
      end else if (cmd.exec) begin
         status_in = STAT_DONE;
         if (is_push) begin
            if (full_now) begin
               status_in = STAT_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               if (empty_now) begin
                  front_in = '0;
                  rear_in  = '0;
                  wr_addr  = '0;
               end else if (req_word.action == ACT_PUSH_FRONT) begin
                  front_in = wrap_dec(front_ff, eff_cap);
                  wr_addr  = front_in;
               end else begin
                  rear_in = wrap_inc(rear_ff, eff_cap);
                  wr_addr = rear_in;
               end
            end
         end else begin
            if (empty_now) begin
               status_in = STAT_UNDERFLOW;
            end else if (count_ff == CW'(1)) begin
               count_in = '0;
               front_in = '0;
               rear_in  = '0;
            end else begin
               count_in = count_ff - CW'(1);
               if (req_word.action == ACT_POP_FRONT) begin
                  front_in = wrap_inc(front_ff, eff_cap);
               end else begin
                  rear_in = wrap_dec(rear_ff, eff_cap);
               end
            end
         end
      end
   end

   always_comb begin
      rsp_word_in.status      = status_ff;
      rsp_word_in.is_empty    = empty_now;
      rsp_word_in.is_full     = full_now;
      rsp_word_in.ends_valid  = !empty_now;
      rsp_word_in.front_value = empty_now ? '0 : front_rd_ff;
      rsp_word_in.rear_value  = empty_now ? '0 : rear_rd_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (cmd.load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_word.value;
      end
   end

   always_ff @(posedge clock) begin
      front_rd_ff <= mem[front_ff];
      rear_rd_ff  <= mem[rear_ff];
   end

   assign dp_status.rsp_busy = rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_word           = rsp_word_ff;

endmodule

`default_nettype wire

[src/circular_deque.sv]
// Top level of the circular deque
// A double-ended queue of signed 32-bit words in a ring of DEPTH entries, of which the
// capacity register selects how many are used (0 acts as 1, above DEPTH acts as DEPTH).
// Each request word pushes or pops at either end and yields one response word with a
// status, the empty and full flags and the front and rear words after the action. A word
// is taken only when idle: the accepting edge updates the indices and writes the ring
// memory, the next edge reads both ends through the registered read ports, and the
// response register loads once the old one is taken or gone, which frees the input side
// while it waits. A capacity write empties the deque at once; no clearing pass follows reset.
`default_nettype none

module circular_deque #(
   parameter int DEPTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  cdq_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output cdq_pkg::rsp_word_type        rsp_word,
   input  wire                          csr_wr_en,
   input  wire [cdq_pkg::CAP_W-1:0]     csr_wr_data
);
   import cdq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   cdq_ctrl u_cdq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_cdq_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

[src/cdq_checker.sv]
// Port checker of the circular deque and its bind to the top level
`default_nettype none
`include "circular_deque_macros.svh"

module cdq_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input cdq_pkg::rsp_word_type rsp_word
);
   import cdq_pkg::*;

   logic rsp_stall;
   logic rsp_error;
   logic ends_flag_ok;
   logic ends_zero;
   logic status_flags_ok;

   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign rsp_error       = rsp_valid && (rsp_word.status != STAT_DONE);
   assign ends_flag_ok    = rsp_word.is_empty != rsp_word.ends_valid;
   assign ends_zero       = !rsp_word.is_full && (rsp_word.front_value == '0) &&
                            (rsp_word.rear_value == '0);
   assign status_flags_ok = (rsp_word.status == STAT_OVERFLOW && rsp_word.is_full) ||
                            (rsp_word.status == STAT_UNDERFLOW && rsp_word.is_empty);

   `CDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))
   `CDQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `CDQ_ASSERT_SAME(a_empty_ends, clock, reset, rsp_valid, ends_flag_ok)
   `CDQ_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && rsp_word.is_empty, ends_zero)
   `CDQ_ASSERT_SAME(a_status_flags, clock, reset, rsp_error, status_flags_ok)

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire

[bench/circular_deque_checker.sv]
// Checker for the circular deque: predicts each response word and compares it
`timescale 1ns / 100ps

module circular_deque_checker #(
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  cdq_pkg::req_word_type   req_word,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  cdq_pkg::rsp_word_type   rsp_word,
   input  wire                     csr_wr_en,
   input  wire [cdq_pkg::CAP_W-1:0] csr_wr_data,
   output int                      fail_total,
   output int                      words_in_flight
);
   import cdq_pkg::*;

   logic signed [VALUE_W-1:0] ring_entries [DEPTH];
   logic [CAP_W-1:0]          cap_setting;
   int                        head_pos;
   int                        tail_pos;
   int                        live_entries;
   rsp_word_type              expected_words [$];

   initial begin
      fail_total = 0;
      words_in_flight = 0;
   end

   function automatic int ring_size();
      if (cap_setting == 0) return 1;
      if (cap_setting > DEPTH) return DEPTH;
      return int'(cap_setting);
   endfunction

   function automatic rsp_word_type apply_action(req_word_type w);
      rsp_word_type r;
      int           cap;
      cap = ring_size();
      r = '0;
      r.status = STAT_DONE;
      if (w.action == ACT_PUSH_FRONT || w.action == ACT_PUSH_REAR) begin
         if (live_entries >= cap) begin
            r.status = STAT_OVERFLOW;
         end else begin
            if (live_entries == 0) begin
               head_pos = 0;
               tail_pos = 0;
               ring_entries[0] = w.value;
            end else if (w.action == ACT_PUSH_FRONT) begin
               head_pos = (head_pos == 0) ? cap - 1 : head_pos - 1;
               ring_entries[head_pos] = w.value;
            end else begin
               tail_pos = (tail_pos + 1 >= cap) ? 0 : tail_pos + 1;
               ring_entries[tail_pos] = w.value;
            end
            live_entries++;
         end
      end else begin
         if (live_entries == 0) begin
            r.status = STAT_UNDERFLOW;
         end else if (live_entries == 1) begin
            live_entries = 0;
            head_pos = 0;
            tail_pos = 0;
         end else begin
            if (w.action == ACT_POP_FRONT)
               head_pos = (head_pos + 1 >= cap) ? 0 : head_pos + 1;
            else
               tail_pos = (tail_pos == 0) ? cap - 1 : tail_pos - 1;
            live_entries--;
         end
      end
      r.is_empty = (live_entries == 0);
      r.is_full = (live_entries >= cap);
      if (live_entries != 0) begin
         r.front_value = ring_entries[head_pos];
         r.rear_value = ring_entries[tail_pos];
         r.ends_valid = 1'b1;
      end
      return r;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         cap_setting = CAP_RESET;
         head_pos = 0;
         tail_pos = 0;
         live_entries = 0;
         expected_words.delete();
         words_in_flight <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with no request pending");
               fail_total++;
            end else begin
               want = expected_words.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_word.status));
               compare_field("is_empty", 32'(want.is_empty), 32'(rsp_word.is_empty));
               compare_field("is_full", 32'(want.is_full), 32'(rsp_word.is_full));
               compare_field("front_value", want.front_value, rsp_word.front_value);
               compare_field("rear_value", want.rear_value, rsp_word.rear_value);
               compare_field("ends_valid", 32'(want.ends_valid), 32'(rsp_word.ends_valid));
            end
         end
         if (csr_wr_en) begin
            cap_setting = csr_wr_data;
            head_pos = 0;
            tail_pos = 0;
            live_entries = 0;
         end
         if (req_valid && req_ready)
            expected_words.push_back(apply_action(req_word));
         words_in_flight <= expected_words.size();
      end
   end

endmodule

[bench/tb_circular_deque.sv]
// Testbench top for the circular deque: stimulus, response stalls and verdict
`timescale 1ns / 100ps

module tb_circular_deque;
   import cdq_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 150;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_word_type     req_word = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   int fail_total;
   int words_in_flight;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit gaps_on = 1'b0;
   bit stalls_on = 1'b0;

   always #6 clock = ~clock;

   circular_deque dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   circular_deque_checker bench_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_total      (fail_total),
      .words_in_flight (words_in_flight)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(1, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(action_type act, logic [VALUE_W-1:0] val);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word.action <= act;
      req_word.value <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_in_flight != 0);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(int push_pct);
      action_type         act;
      logic [VALUE_W-1:0] val;
      if ($urandom_range(0, 99) < push_pct)
         act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
      else
         act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
      case ($urandom_range(0, 9))
         0: val = 32'h8000_0000;
         1: val = 32'h7FFF_FFFF;
         2: val = 32'hFFFF_FFFF;
         3: val = 32'h0000_0000;
         default: val = $urandom;
      endcase
      send_word(act, val);
   endtask

   initial begin
      int               push_pct;
      logic [CAP_W-1:0] cap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(ACT_POP_FRONT, 32'h1234_5678);
      send_word(ACT_POP_REAR, 32'h0);
      send_word(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
      send_word(ACT_PUSH_FRONT, 32'h8000_0000);
      send_word(ACT_PUSH_REAR, 32'h0000_0000);
      send_word(ACT_POP_FRONT, 32'h0);
      send_word(ACT_POP_REAR, 32'h0);
      send_word(ACT_POP_FRONT, 32'h0);
      wait_drained();
      write_capacity(5'd2);
      send_word(ACT_PUSH_REAR, 32'hFFFF_FFFF);
      send_word(ACT_PUSH_FRONT, 32'h5555_5555);
      send_word(ACT_PUSH_REAR, 32'h0000_0001);
      send_word(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
      send_word(ACT_POP_REAR, 32'h0);
      send_word(ACT_PUSH_REAR, 32'hAAAA_AAAA);
      send_word(ACT_POP_FRONT, 32'h0);
      send_word(ACT_POP_REAR, 32'h0);
      send_word(ACT_POP_FRONT, 32'h0);
      wait_drained();
      write_capacity(5'd0);
      send_word(ACT_PUSH_REAR, 32'h0F0F_0F0F);
      send_word(ACT_PUSH_FRONT, 32'hF0F0_F0F0);
      send_word(ACT_POP_FRONT, 32'h0);
      send_word(ACT_POP_REAR, 32'h0);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: cap = 5'd16;
            1: cap = 5'd1;
            2: cap = 5'd31;
            3: cap = 5'd0;
            4: cap = 5'd17;
            5: cap = 5'd4;
            6: cap = 5'd8;
            7: cap = 5'd15;
            8: cap = 5'd3;
            default: cap = CAP_W'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         gaps_on <= (ph < PHASES - 2) && (ph % 3 != 2);
         stalls_on <= (ph < PHASES - 2) && (ph % 4 != 3);
         push_pct = 50;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 24 == 0)
               case ($urandom_range(0, 2))
                  0: push_pct = 15;
                  1: push_pct = 50;
                  default: push_pct = 85;
               endcase
            send_random(push_pct);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_total == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/cdq_pkg.sv
src/cdq_ctrl.sv
src/cdq_datapath.sv
src/circular_deque.sv
src/cdq_checker.sv
bench/circular_deque_checker.sv
bench/tb_circular_deque.sv
